[rtl/sof_length_frame_deframer_defines.svh]
// assertion helpers shared by the deframer rtl
`ifndef SOF_LENGTH_FRAME_DEFRAMER_DEFINES_SVH
`define SOF_LENGTH_FRAME_DEFRAMER_DEFINES_SVH

`ifndef NO_ASSERTIONS

// checked on every clock edge outside reset
`define SLFD_ASSERT(name, prop, msg) \
   name: assert property (@(posedge clock) disable iff (reset) (prop)) else $error(msg);

// checked on every clock edge, reset included
`define SLFD_ASSERT_ALWAYS(name, prop, msg) \
   name: assert property (@(posedge clock) (prop)) else $error(msg);

`else

`define SLFD_ASSERT(name, prop, msg)
`define SLFD_ASSERT_ALWAYS(name, prop, msg)

`endif

`endif

[rtl/slfd_pkg.sv]
package slfd_pkg;

   localparam int BYTE_W  = 8;
   localparam int WORD_W  = 16;
   localparam int PHASE_W = 3;

   // frame parser phases
   localparam logic [PHASE_W-1:0] PH_SOF_HI = 3'd0;
   localparam logic [PHASE_W-1:0] PH_SOF_LO = 3'd1;
   localparam logic [PHASE_W-1:0] PH_LEN_HI = 3'd2;
   localparam logic [PHASE_W-1:0] PH_LEN_LO = 3'd3;
   localparam logic [PHASE_W-1:0] PH_DATA   = 3'd4;

   typedef struct packed {
      logic              vld;
      logic [BYTE_W-1:0] payload_byte;
      logic [WORD_W-1:0] byte_index;
      logic [WORD_W-1:0] frame_length;
      logic              last_of_frame;
      logic              empty_frame;
   } slfd_result_type;

endpackage

[rtl/sof_length_frame_deframer.sv]
// Length-prefixed frame deframer. Received bytes enter on the req_ channel, one per
// transfer; the block hunts for the two-byte start word set through csr_wr_data (bits 15..8
// first), then reads a 16-bit big-endian payload length and sends every payload byte out
// on the rsp_ channel with its index, the declared length and a last-of-frame flag. A
// declared length of zero gives one result with empty_frame and last_of_frame set and
// zero payload. Header bytes produce no result. Throughput is one byte per clock while the
// result register is not held by rsp_stall: a one-byte input register feeds combinational
// parser logic into a one-entry result register that holds each result. The input side is
// stalled only while a result is due and the result register is still held by rsp_stall.
// The start word resets to zero and should be written only while no frame is in flight.
`include "sof_length_frame_deframer_defines.svh"

module sof_length_frame_deframer (
   input  logic                        clock,
   input  logic                        reset,
   // start word register
   input  logic                        csr_wr_en,
   input  logic [slfd_pkg::WORD_W-1:0] csr_wr_data,
   // received bytes
   input  logic                        req_valid,
   output logic                        req_stall,
   input  logic [slfd_pkg::BYTE_W-1:0] req_rx_byte,
   // payload results
   output logic                        rsp_valid,
   input  logic                        rsp_stall,
   output logic [slfd_pkg::BYTE_W-1:0] rsp_payload_byte,
   output logic [slfd_pkg::WORD_W-1:0] rsp_byte_index,
   output logic [slfd_pkg::WORD_W-1:0] rsp_frame_length,
   output logic                        rsp_last_of_frame,
   output logic                        rsp_empty_frame
);
   import slfd_pkg::*;

   logic              in_vld;
   logic [BYTE_W-1:0] in_byte;
   logic              out_free;
   logic              advance;
   slfd_result_type   res;

   // a byte moves through the parser when it has nowhere to go (header byte)
   // or when the result register can take its result this edge
   assign advance = in_vld && (!res.vld || out_free);

   slfd_in_stage u_in_stage (
      .clock       (clock),
      .reset       (reset),
      .req_valid   (req_valid),
      .req_stall   (req_stall),
      .req_rx_byte (req_rx_byte),
      .advance     (advance),
      .in_vld      (in_vld),
      .in_byte     (in_byte)
   );

   // start word, phase, length and count live here
   slfd_core u_core (
      .clock       (clock),
      .reset       (reset),
      .csr_wr_en   (csr_wr_en),
      .csr_wr_data (csr_wr_data),
      .in_vld      (in_vld),
      .in_byte     (in_byte),
      .advance     (advance),
      .res         (res)
   );

   slfd_out_reg u_out_reg (
      .clock             (clock),
      .reset             (reset),
      .res               (res),
      .advance           (advance),
      .out_free          (out_free),
      .rsp_valid         (rsp_valid),
      .rsp_stall         (rsp_stall),
      .rsp_payload_byte  (rsp_payload_byte),
      .rsp_byte_index    (rsp_byte_index),
      .rsp_frame_length  (rsp_frame_length),
      .rsp_last_of_frame (rsp_last_of_frame),
      .rsp_empty_frame   (rsp_empty_frame)
   );

   // the input side only stalls when a byte is already held
   `SLFD_ASSERT(a_stall_needs_held_byte, req_stall |-> in_vld, "input stalled with empty input register")

endmodule

[rtl/slfd_in_stage.sv]
module slfd_in_stage (
   input  logic                      clock,
   input  logic                      reset,
   input  logic                      req_valid,
   output logic                      req_stall,
   input  logic [slfd_pkg::BYTE_W-1:0] req_rx_byte,
   input  logic                      advance,
   output logic                      in_vld,
   output logic [slfd_pkg::BYTE_W-1:0] in_byte
);
   import slfd_pkg::*;

   logic              in_vld_ff;
   logic              in_vld_in;
   logic [BYTE_W-1:0] in_byte_ff;
   logic [BYTE_W-1:0] in_byte_in;
   logic              take;

   // held byte leaves this cycle or the slot is empty
   assign req_stall = in_vld_ff && !advance;
   assign take      = req_valid && !req_stall;

   always_comb begin
      in_vld_in  = in_vld_ff;
      in_byte_in = in_byte_ff;
      if (take) begin
         in_vld_in  = 1'b1;
         in_byte_in = req_rx_byte;
      end else if (advance) begin
         in_vld_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         in_vld_ff <= 1'b0;
      end else begin
         in_vld_ff <= in_vld_in;
      end
      in_byte_ff <= in_byte_in;
   end

   assign in_vld  = in_vld_ff;
   assign in_byte = in_byte_ff;

endmodule

[rtl/slfd_core.sv]
`include "sof_length_frame_deframer_defines.svh"

module slfd_core (
   input  logic                        clock,
   input  logic                        reset,
   input  logic                        csr_wr_en,
   input  logic [slfd_pkg::WORD_W-1:0] csr_wr_data,
   input  logic                        in_vld,
   input  logic [slfd_pkg::BYTE_W-1:0] in_byte,
   input  logic                        advance,
   output slfd_pkg::slfd_result_type   res
);
   import slfd_pkg::*;

   logic [WORD_W-1:0]  start_word_ff;
   logic [PHASE_W-1:0] phase_ff;
   logic [PHASE_W-1:0] phase_in;
   logic [WORD_W-1:0]  len_ff;
   logic [WORD_W-1:0]  len_in;
   logic [WORD_W-1:0]  count_ff;
   logic [WORD_W-1:0]  count_in;
   logic [BYTE_W-1:0]  sof_hi;
   logic [BYTE_W-1:0]  sof_lo;
   logic [WORD_W:0]    count_inc;
   logic [WORD_W-1:0]  full_len;

   assign sof_hi    = start_word_ff[WORD_W-1:BYTE_W];
   assign sof_lo    = start_word_ff[BYTE_W-1:0];
   assign count_inc = {1'b0, count_ff} + {{WORD_W{1'b0}}, 1'b1};
   assign full_len  = {len_ff[BYTE_W-1:0], in_byte};

   always_comb begin
      phase_in = phase_ff;
      len_in   = len_ff;
      count_in = count_ff;
      res      = '0;
      case (phase_ff)
         PH_SOF_LO: begin
            if (in_byte == sof_lo) begin
               phase_in = PH_LEN_HI;
            end else if (in_byte != sof_hi) begin
               phase_in = PH_SOF_HI;
            end
         end
         PH_LEN_HI: begin
            len_in   = {{(WORD_W-BYTE_W){1'b0}}, in_byte};
            phase_in = PH_LEN_LO;
         end
         PH_LEN_LO: begin
            len_in   = full_len;
            count_in = '0;
            if (full_len == '0) begin
               // zero length: one empty-frame result, straight back to hunting
               phase_in          = PH_SOF_HI;
               res.vld           = 1'b1;
               res.last_of_frame = 1'b1;
               res.empty_frame   = 1'b1;
            end else begin
               phase_in = PH_DATA;
            end
         end
         PH_DATA: begin
            count_in          = count_inc[WORD_W-1:0];
            res.vld           = 1'b1;
            res.payload_byte  = in_byte;
            res.byte_index    = count_ff;
            res.frame_length  = len_ff;
            res.last_of_frame = (count_inc == {1'b0, len_ff});
            if (res.last_of_frame) begin
               phase_in = PH_SOF_HI;
            end
         end
         default: begin
            phase_in = (in_byte == sof_hi) ? PH_SOF_LO : PH_SOF_HI;
         end
      endcase
      if (!in_vld) begin
         res.vld = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         start_word_ff <= '0;
         phase_ff      <= PH_SOF_HI;
         len_ff        <= '0;
         count_ff      <= '0;
      end else begin
         if (csr_wr_en) begin
            start_word_ff <= csr_wr_data;
         end
         if (advance) begin
            phase_ff <= phase_in;
            len_ff   <= len_in;
            count_ff <= count_in;
         end
      end
   end

   `SLFD_ASSERT(a_data_count_in_range, (phase_ff == PH_DATA) |-> (count_ff < len_ff), "payload count reached declared length while in payload phase")
   `SLFD_ASSERT(a_empty_is_last, (res.vld && res.empty_frame) |-> (res.last_of_frame && res.frame_length == '0), "empty frame result not marked last with zero length")

endmodule

[rtl/slfd_out_reg.sv]
`include "sof_length_frame_deframer_defines.svh"

module slfd_out_reg (
   input  logic                        clock,
   input  logic                        reset,
   input  slfd_pkg::slfd_result_type   res,
   input  logic                        advance,
   output logic                        out_free,
   output logic                        rsp_valid,
   input  logic                        rsp_stall,
   output logic [slfd_pkg::BYTE_W-1:0] rsp_payload_byte,
   output logic [slfd_pkg::WORD_W-1:0] rsp_byte_index,
   output logic [slfd_pkg::WORD_W-1:0] rsp_frame_length,
   output logic                        rsp_last_of_frame,
   output logic                        rsp_empty_frame
);
   import slfd_pkg::*;

   logic            vld_ff;
   logic            vld_in;
   slfd_result_type data_ff;
   slfd_result_type data_in;
   logic            load;

   assign out_free = !vld_ff || !rsp_stall;
   assign load     = advance && res.vld;

   always_comb begin
      data_in = data_ff;
      vld_in  = vld_ff;
      if (load) begin
         data_in = res;
         vld_in  = 1'b1;
      end else if (!rsp_stall) begin
         vld_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         vld_ff <= 1'b0;
      end else begin
         vld_ff <= vld_in;
      end
      data_ff <= data_in;
   end

   assign rsp_valid         = vld_ff;
   assign rsp_payload_byte  = data_ff.payload_byte;
   assign rsp_byte_index    = data_ff.byte_index;
   assign rsp_frame_length  = data_ff.frame_length;
   assign rsp_last_of_frame = data_ff.last_of_frame;
   assign rsp_empty_frame   = data_ff.empty_frame;

   `SLFD_ASSERT(a_no_overwrite, (vld_ff && rsp_stall) |-> !load, "pending result overwritten while stalled")

endmodule
